// ===== src/iirl_pkg.sv =====
// ----------------------------------------------------------------------------
// iirl_pkg: shared types and codes for the indexed insert/remove list
// Request modes, status codes, field widths and the per-cell control word.
// ----------------------------------------------------------------------------
package iirl_pkg;

  // Field widths of the request and response payloads
  localparam int MODE_W  = 3;
  localparam int INDEX_W = 8;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = 5;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GET    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

  // Response status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // What a cell loads on the next edge
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LEFT,
    SEL_RIGHT,
    SEL_NEW
  } cell_sel_t;

  typedef struct packed {
    cell_sel_t sel;
  } cell_ctl_t;

endpackage

// ===== src/iirl_ifs.sv =====
// ----------------------------------------------------------------------------
// iirl request/response channels
// Valid/ready channels carrying list requests and their responses.
// ----------------------------------------------------------------------------
interface iirl_req_if;
  logic                         valid;
  logic                         ready;
  logic [iirl_pkg::MODE_W-1:0]  mode;
  logic [iirl_pkg::INDEX_W-1:0] index;
  logic [iirl_pkg::DATA_W-1:0]  value;

  modport source (output valid, output mode, output index, output value, input ready);
  modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

interface iirl_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [iirl_pkg::STAT_W-1:0] status;
  logic [iirl_pkg::DATA_W-1:0] read_value;
  logic [iirl_pkg::LEN_W-1:0]  length_now;

  modport source (output valid, output status, output read_value, output length_now,
                  input ready);
  modport sink   (input valid, input status, input read_value, input length_now,
                  output ready);
endinterface

// ===== src/iirl_cell.sv =====
// ----------------------------------------------------------------------------
// iirl_cell: one storage slot of the list
// Holds a word, or loads its left neighbor, its right neighbor or a new word.
// ----------------------------------------------------------------------------
module iirl_cell #(
  parameter int W = 32
) (
  input  logic                clk,
  input  iirl_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]        left,
  input  logic [W-1:0]        right,
  input  logic [W-1:0]        fresh,
  output logic [W-1:0]        word
);

  logic [W-1:0] word_next;

  always_comb begin
    unique case (ctl.sel)
      iirl_pkg::SEL_HOLD:  word_next = word;
      iirl_pkg::SEL_LEFT:  word_next = left;
      iirl_pkg::SEL_RIGHT: word_next = right;
      iirl_pkg::SEL_NEW:   word_next = fresh;
      default:             word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ===== src/indexed_insert_remove_list.sv =====
// The response to a request is registered: it is valid in the cycle after the edge that accepts the request.
// Throughput: one request per cycle while the sink takes each response; each cell shifts, holds or loads at that edge.
// Input ready drops only while a finished response waits and the sink is stalled.
// Reset: synchronous, active high; clears the length and the response valid.
// Stored words are not cleared; only entries below the length are ever read.
// ----------------------------------------------------------------------------
// indexed_insert_remove_list: fixed-capacity ordered list of words
// Push, pop, insert at index, remove at index, get at index and clear, built
// as a row of cells that each hold one word and trade with their neighbors.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list #(
  parameter int DEPTH         = 16,
  parameter int ELEMENT_WIDTH = 32
) (
  input logic        clk,
  input logic        rst,
  iirl_req_if.sink   req,
  iirl_rsp_if.source rsp
);

  localparam int CW   = $clog2(DEPTH + 1);                               // length counter
  localparam int CMPW = (CW > iirl_pkg::INDEX_W) ? CW : iirl_pkg::INDEX_W; // compare width
  localparam int DW   = iirl_pkg::DATA_W;
  localparam int LW   = iirl_pkg::LEN_W;
  localparam int SW   = iirl_pkg::STAT_W;
  localparam int EW   = ELEMENT_WIDTH;

  // --------------------------------------------------------------------------
  // State: length register and the response register
  // --------------------------------------------------------------------------
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic          rsp_valid;
  logic [SW-1:0] rsp_status;
  logic [DW-1:0] rsp_read;
  logic [LW-1:0] rsp_len;

  // Request fires when the response slot is free or being drained this cycle
  logic fire;
  assign req.ready = !rsp_valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  // --------------------------------------------------------------------------
  // Request decode: status, new length, and what kind of cell move
  // --------------------------------------------------------------------------
  logic [CMPW-1:0] idx_c;
  logic [CMPW-1:0] cnt_c;
  logic            full;
  logic [SW-1:0]   status;
  logic            wr;       // a word is placed (push or insert)
  logic            rm;       // later words shift down
  logic            rd_ok;    // successful get
  logic [CMPW-1:0] ins_pos;

  assign idx_c = CMPW'(req.index);
  assign cnt_c = CMPW'(count);
  assign full  = (count == CW'(DEPTH));

  always_comb begin
    status     = iirl_pkg::ST_OK;
    count_next = count;
    wr         = 1'b0;
    rm         = 1'b0;
    rd_ok      = 1'b0;
    ins_pos    = idx_c;
    unique case (req.mode)
      iirl_pkg::MODE_PUSH: begin
        ins_pos = cnt_c;
        if (full) begin
          status = iirl_pkg::ST_FULL;
        end else begin
          wr         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      iirl_pkg::MODE_POP: begin
        if (count == '0) begin
          status = iirl_pkg::ST_RANGE;
        end else begin
          count_next = count - CW'(1);
        end
      end
      iirl_pkg::MODE_INSERT: begin
        // Range check wins over the full check
        if (idx_c > cnt_c) begin
          status = iirl_pkg::ST_RANGE;
        end else if (full) begin
          status = iirl_pkg::ST_FULL;
        end else begin
          wr         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      iirl_pkg::MODE_REMOVE: begin
        if (idx_c >= cnt_c) begin
          status = iirl_pkg::ST_RANGE;
        end else begin
          rm         = 1'b1;
          count_next = count - CW'(1);
        end
      end
      iirl_pkg::MODE_GET: begin
        if (idx_c >= cnt_c) begin
          status = iirl_pkg::ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      iirl_pkg::MODE_CLEAR: begin
        count_next = '0;
      end
      default: begin
        // unused modes answer out of range and change nothing
        status = iirl_pkg::ST_RANGE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Per-cell control. Inserted word lands at ins_pos; cells above it up to the
  // old length take their left neighbor. On remove, cells from the index up to
  // the new last entry take their right neighbor.
  // --------------------------------------------------------------------------
  iirl_pkg::cell_ctl_t ctl [DEPTH];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].sel = iirl_pkg::SEL_HOLD;
      if (fire) begin
        if (wr && CMPW'(i) == ins_pos) begin
          ctl[i].sel = iirl_pkg::SEL_NEW;
        end else if (wr && CMPW'(i) > ins_pos && CMPW'(i) <= cnt_c) begin
          ctl[i].sel = iirl_pkg::SEL_LEFT;
        end else if (rm && CMPW'(i) >= idx_c && (CMPW'(i) + CMPW'(1)) < cnt_c) begin
          ctl[i].sel = iirl_pkg::SEL_RIGHT;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Row of cells
  // --------------------------------------------------------------------------
  logic [EW-1:0] fresh;
  logic [EW-1:0] cell_word [DEPTH];

  assign fresh = EW'(req.value);   // words are masked to the element width

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [EW-1:0] left_w;
    logic [EW-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end

    iirl_cell #(
      .W(EW)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl[g]),
      .left (left_w),
      .right(right_w),
      .fresh(fresh),
      .word (cell_word[g])
    );
  end

  // Get path: select the addressed cell
  logic [EW-1:0] rd_word;

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CMPW'(i) == idx_c) begin
        rd_word = cell_word[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Length and response registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_status <= status;
      rsp_read   <= rd_ok ? DW'(rd_word) : '0;
      rsp_len    <= LW'(count_next);
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.read_value = rsp_read;
  assign rsp.length_now = rsp_len;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("list length above capacity");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == iirl_pkg::ST_FULL |-> rsp_len == LW'(DEPTH))
    else $error("full status with list not at capacity");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != iirl_pkg::ST_OK |-> rsp_read == '0)
    else $error("read data on failed request");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    fire && req.mode != iirl_pkg::MODE_CLEAR |=>
      (count == $past(count) || count == $past(count) + CW'(1) ||
       count == $past(count) - CW'(1)))
    else $error("length moved by more than one");

  a_hold_len: assert property (@(posedge clk) disable iff (rst)
    !fire |=> count == $past(count))
    else $error("length changed without a request");

endmodule
